// ----- rtl/pal_pkg.sv -----
// Package: shared types and codes for the positional array list.
package pal_pkg;

	localparam int POS_W = 7;
	localparam int DATA_W = 32;
	localparam int CNT_OUT_W = 8;
	localparam int GROUP = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_INS_REJECT = 2'd1;
	localparam logic [1:0] ST_DEL_REJECT = 2'd2;

	// Qualified command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic del;
		logic [POS_W-1:0] pos;
		logic [DATA_W-1:0] value;
	} pal_cmd_t;

endpackage

// ----- rtl/pal_cell.sv -----
// Cell: one list entry, shifts with its neighbors on insert and delete.
module pal_cell
	import pal_pkg::*;
#(
	parameter int IDX = 0,
	parameter int IW = 8
) (
	input  logic clk,
	input  pal_cmd_t cmd,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] tap
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [DATA_W-1:0] data_q;
	logic [IW-1:0] pos_ext;
	logic hit;
	logic above;

	assign pos_ext = IW'(cmd.pos);
	assign hit = (MY_IDX == pos_ext);
	assign above = (MY_IDX > pos_ext);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (hit)
				data_q <= cmd.value;
			else if (above)
				data_q <= left;
		end else if (cmd.del && (hit || above)) begin
			data_q <= right;
		end
	end

	assign data = data_q;
	// old contents, offered only by the cell being deleted
	assign tap = (cmd.del && hit) ? data_q : '0;

endmodule

// ----- rtl/pal_gather.sv -----
// Gather: registered OR of one group of cell taps.
module pal_gather
	import pal_pkg::*;
(
	input  logic clk,
	input  logic [GROUP-1:0][DATA_W-1:0] taps,
	output logic [DATA_W-1:0] part
);

	logic [DATA_W-1:0] or_c;
	logic [DATA_W-1:0] part_s1;

	always_comb begin
		or_c = '0;
		for (int i = 0; i < GROUP; i++)
			or_c = or_c | taps[i];
	end

	always_ff @(posedge clk) begin
		part_s1 <= or_c;
	end

	assign part = part_s1;

endmodule

// ----- rtl/positional_array_list_top.sv -----
// Positional array list: a row of shifting cells with insert/delete at any position.
// A command is taken when start is high and busy is low. Its result passes through
// a first register stage and the result registers to the result ports, with done
// high for exactly one cycle; the receiver cannot stall it. busy stays high for the
// cycle after each accepted transaction, so a new command waits while busy is high:
// the cells shift at the accept edge, and the deleted value is collected through a
// two-level registered OR over the row. Entries are not cleared at reset; the list
// only ever reads entries below the count, which have all been written.
module positional_array_list_top
	import pal_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic command,
	input  logic [POS_W-1:0] position,
	input  logic signed [DATA_W-1:0] value,
	output logic done,
	output logic [1:0] status,
	output logic signed [DATA_W-1:0] removed_value,
	output logic [CNT_OUT_W-1:0] entry_count,
	output logic empty_flag,
	output logic full_flag
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
	localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic accept;
	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic ins_ok;
	logic del_ok;
	logic [CNT_W-1:0] count_next;
	logic [1:0] status_next;
	pal_cmd_t cmd;

	logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
	logic [NGRP*GROUP-1:0][DATA_W-1:0] taps;
	logic [NGRP-1:0][DATA_W-1:0] parts;
	logic [DATA_W-1:0] removed_c;

	logic pending_q;
	logic [1:0] status_s1;
	logic del_ok_s1;
	logic done_q;
	logic [1:0] status_q;
	logic [DATA_W-1:0] removed_q;
	logic [CNT_W-1:0] count_out_q;

	assign accept = start && !busy;
	assign busy = pending_q;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign ins_ok = (command == CMD_INSERT) && (count_q != CAP_CNT) && (pos_ext <= cnt_ext);
	assign del_ok = (command == CMD_DELETE) && (pos_ext < cnt_ext);

	always_comb begin
		count_next = count_q;
		status_next = ST_DONE;
		if (command == CMD_INSERT) begin
			if (ins_ok)
				count_next = count_q + CNT_W'(1);
			else
				status_next = ST_INS_REJECT;
		end else begin
			if (del_ok)
				count_next = count_q - CNT_W'(1);
			else
				status_next = ST_DEL_REJECT;
		end
	end

	assign cmd.ins = accept && ins_ok;
	assign cmd.del = accept && del_ok;
	assign cmd.pos = position;
	assign cmd.value = value;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_c;
		logic [DATA_W-1:0] right_c;
		if (i == 0) begin : g_first
			assign left_c = cell_data[i];
		end else begin : g_left
			assign left_c = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_c = cell_data[i];
		end else begin : g_right
			assign right_c = cell_data[i+1];
		end
		pal_cell #(
			.IDX(i),
			.IW(CMP_W)
		) u_cell (
			.clk(clk),
			.cmd(cmd),
			.left(left_c),
			.right(right_c),
			.data(cell_data[i]),
			.tap(taps[i])
		);
	end

	for (genvar i = CAPACITY; i < NGRP * GROUP; i++) begin : g_pad
		assign taps[i] = '0;
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		pal_gather u_gather (
			.clk(clk),
			.taps(taps[g*GROUP +: GROUP]),
			.part(parts[g])
		);
	end

	always_comb begin
		removed_c = '0;
		for (int g = 0; g < NGRP; g++)
			removed_c = removed_c | parts[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pending_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pending_q <= accept;
			done_q <= pending_q;
			if (accept)
				count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_next;
			del_ok_s1 <= del_ok;
		end
		if (pending_q) begin
			status_q <= status_s1;
			removed_q <= del_ok_s1 ? removed_c : '0;
			count_out_q <= count_q;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign removed_value = removed_q;
	assign entry_count = CNT_OUT_W'(count_out_q);
	assign empty_flag = (count_out_q == '0);
	assign full_flag = (count_out_q == CAP_CNT);

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the positional array list.
`timescale 1ns / 1ps

module testbench;
	import pal_pkg::*;

	localparam int LIST_CAP = 128;
	localparam int RAND_ITEMS = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int N_DIR = 17;
	localparam int MAX_PRINTS = 40;

	typedef enum int {FILLING, DRAINING, MIXING} phase_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [DATA_W-1:0] removed;
		logic [CNT_OUT_W-1:0] count;
		logic empty;
		logic full;
	} list_result_t;

	typedef struct packed {
		logic cmd;
		logic [POS_W-1:0] pos;
		logic signed [DATA_W-1:0] val;
		logic fixed_res;
		list_result_t res;
	} list_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic command = CMD_INSERT;
	logic [POS_W-1:0] position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic signed [DATA_W-1:0] removed_value;
	logic [CNT_OUT_W-1:0] entry_count;
	logic empty_flag;
	logic full_flag;

	// predicted list contents and length
	logic signed [DATA_W-1:0] list_mem [LIST_CAP];
	int list_len = 0;

	list_result_t result_q [$];
	list_row_t dir_rows [N_DIR];
	list_result_t got_res;
	list_result_t want_res;
	int err_cnt = 0;
	int cycle_cnt = 0;
	bit no_gap_run = 1'b0;

	positional_array_list_top #(
		.CAPACITY(LIST_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.position(position),
		.value(value),
		.done(done),
		.status(status),
		.removed_value(removed_value),
		.entry_count(entry_count),
		.empty_flag(empty_flag),
		.full_flag(full_flag)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string msg);
		if (err_cnt < MAX_PRINTS) begin
			$display("MISMATCH @%0t: %s", $time, msg);
		end
		err_cnt++;
	endtask

	function automatic list_result_t list_apply(input logic cmd, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		list_result_t res;
		int i;
		res = '0;
		if (cmd == CMD_INSERT) begin
			if (list_len >= LIST_CAP || int'(pos) > list_len) begin
				res.status = ST_INS_REJECT;
			end else begin
				for (i = list_len; i > int'(pos); i--) list_mem[i] = list_mem[i-1];
				list_mem[pos] = val;
				list_len++;
			end
		end else begin
			if (int'(pos) >= list_len) begin
				res.status = ST_DEL_REJECT;
			end else begin
				res.removed = list_mem[pos];
				for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
				list_len--;
			end
		end
		res.count = CNT_OUT_W'(list_len);
		res.empty = (list_len == 0);
		res.full = (list_len == LIST_CAP);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if ($urandom_range(49) == 0) no_gap_run = ~no_gap_run;
		if (no_gap_run || r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	task automatic issue_cmd(input list_row_t row);
		list_result_t pred;
		int gap;
		start <= 1'b1;
		command <= row.cmd;
		position <= row.pos;
		value <= row.val;
		@(posedge clk);
		while (busy) @(posedge clk);
		// transaction taken at this edge
		pred = list_apply(row.cmd, row.pos, row.val);
		result_q.push_back(row.fixed_res ? row.res : pred);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(input logic cmd);
		int r;
		int hi;
		r = $urandom_range(99);
		if (r < 8) return POS_W'($urandom_range(127));
		if (r < 18) return '0;
		if (cmd == CMD_INSERT) begin
			hi = (list_len > 127) ? 127 : list_len;
			if (r < 30) return POS_W'(hi);
			return POS_W'($urandom_range(hi));
		end
		if (list_len == 0) return POS_W'($urandom_range(3));
		if (r < 30) return POS_W'(list_len - 1);
		return POS_W'($urandom_range(list_len - 1));
	endfunction

	// compare each strobed result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_res = '{status, removed_value, entry_count, empty_flag, full_flag};
			if (result_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result status=%0d count=%0d",
					status, entry_count));
			end else begin
				want_res = result_q.pop_front();
				if (got_res.status !== want_res.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got_res.status, want_res.status));
				if (got_res.removed !== want_res.removed)
					report_mismatch($sformatf("removed_value got %h want %h",
						got_res.removed, want_res.removed));
				if (got_res.count !== want_res.count)
					report_mismatch($sformatf("entry_count got %0d want %0d",
						got_res.count, want_res.count));
				if (got_res.empty !== want_res.empty)
					report_mismatch($sformatf("empty_flag got %b want %b",
						got_res.empty, want_res.empty));
				if (got_res.full !== want_res.full)
					report_mismatch($sformatf("full_flag got %b want %b",
						got_res.full, want_res.full));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		list_row_t row;
		phase_t phase;
		int sent;
		int phase_left;
		logic cmd;

		dir_rows = '{
			// delete on empty list, insert past count
			'{CMD_DELETE, 7'd0, 32'sd0, 1'b1, '{ST_DEL_REJECT, 32'sd0, 8'd0, 1'b1, 1'b0}},
			'{CMD_INSERT, 7'd1, 32'sd5, 1'b1, '{ST_INS_REJECT, 32'sd0, 8'd0, 1'b1, 1'b0}},
			'{CMD_INSERT, 7'd0, 32'sh7FFF_FFFF, 1'b1, '{ST_DONE, 32'sd0, 8'd1, 1'b0, 1'b0}},
			'{CMD_INSERT, 7'd0, 32'sh8000_0000, 1'b1, '{ST_DONE, 32'sd0, 8'd2, 1'b0, 1'b0}},
			// position equal to count appends
			'{CMD_INSERT, 7'd2, -32'sd1, 1'b1, '{ST_DONE, 32'sd0, 8'd3, 1'b0, 1'b0}},
			'{CMD_INSERT, 7'd1, 32'sd0, 1'b0, '0},
			'{CMD_INSERT, 7'd127, 32'sd9, 1'b1, '{ST_INS_REJECT, 32'sd0, 8'd4, 1'b0, 1'b0}},
			'{CMD_DELETE, 7'd4, 32'sd0, 1'b1, '{ST_DEL_REJECT, 32'sd0, 8'd4, 1'b0, 1'b0}},
			'{CMD_DELETE, 7'd127, 32'sd0, 1'b1, '{ST_DEL_REJECT, 32'sd0, 8'd4, 1'b0, 1'b0}},
			// value field is don't-care on delete
			'{CMD_DELETE, 7'd0, 32'sh1234_5678, 1'b1,
				'{ST_DONE, 32'sh8000_0000, 8'd3, 1'b0, 1'b0}},
			'{CMD_DELETE, 7'd2, 32'sd0, 1'b1, '{ST_DONE, -32'sd1, 8'd2, 1'b0, 1'b0}},
			'{CMD_INSERT, 7'd1, 32'sh55AA_55AA, 1'b0, '0},
			'{CMD_DELETE, 7'd1, 32'sd0, 1'b0, '0},
			'{CMD_DELETE, 7'd0, 32'sd0, 1'b0, '0},
			'{CMD_DELETE, 7'd0, 32'sd0, 1'b1, '{ST_DONE, 32'sh7FFF_FFFF, 8'd0, 1'b1, 1'b0}},
			'{CMD_DELETE, 7'd0, 32'sd0, 1'b1, '{ST_DEL_REJECT, 32'sd0, 8'd0, 1'b1, 1'b0}},
			'{CMD_INSERT, 7'd0, 32'shAAAA_AAAA, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_DIR; k++) issue_cmd(dir_rows[k]);

		// fill to full, drain to empty, then wander; repeat
		phase = FILLING;
		phase_left = 0;
		for (sent = 0; sent < RAND_ITEMS; sent++) begin
			case (phase)
				FILLING: begin
					cmd = ($urandom_range(99) < 85) ? CMD_INSERT : CMD_DELETE;
					if (list_len == LIST_CAP && phase_left == 0) phase_left = $urandom_range(6, 3);
				end
				DRAINING: begin
					cmd = ($urandom_range(99) < 85) ? CMD_DELETE : CMD_INSERT;
					if (list_len == 0 && phase_left == 0) phase_left = $urandom_range(5, 2);
				end
				default: begin
					cmd = 1'($urandom_range(1));
				end
			endcase
			row = '0;
			row.cmd = cmd;
			row.pos = pick_pos(cmd);
			row.val = pick_value();
			issue_cmd(row);
			if (phase_left > 0) begin
				phase_left--;
				if (phase_left == 0) begin
					case (phase)
						FILLING: phase = DRAINING;
						DRAINING: begin
							phase = MIXING;
							phase_left = $urandom_range(100, 40);
						end
						default: phase = FILLING;
					endcase
				end
			end
		end

		start <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/pal_pkg.sv
rtl/pal_cell.sv
rtl/pal_gather.sv
rtl/positional_array_list_top.sv
test/testbench.sv
